// ===== rtl/bss_pkg.sv =====
package bss_pkg;

  localparam int unsigned MAX_SAMPLES = 151;

  localparam logic [7:0] BOOST_EN_BIT = 8'h20;
  localparam logic [7:0] OTG_MASK     = 8'he0;
  localparam logic [7:0] FAULT_BIT    = 8'h40;
  localparam logic [6:0] VCODE_MIN    = 7'd18;
  localparam logic [7:0] COUNT_MAX    = 8'hff;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1500;

  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 8;

  typedef enum logic [1:0] {
    V_CHECK = 2'd0,
    V_PASS  = 2'd1,
    V_FAIL  = 2'd2
  } verdict_t;

  typedef enum logic [3:0] {
    R_NONE     = 4'd0,
    R_READ     = 4'd1,
    R_CLOCK    = 4'd2,
    R_FAULT    = 4'd3,
    R_DISABLED = 4'd4,
    R_REPEAT   = 4'd5,
    R_UNSTABLE = 4'd6,
    R_TIMEOUT  = 4'd7,
    R_LIMIT    = 4'd8
  } reason_t;

  typedef enum logic [1:0] {
    CFG_WINDOW  = 2'd0,
    CFG_STABLE  = 2'd1,
    CFG_TIMEOUT = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    FUNC_BEGIN  = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_t;

endpackage

// ===== rtl/boost_startup_supervisor.sv =====
// Boost startup supervisor: one result transfer per input transfer, in order. A begin
// item (tuser 0) clears the attempt; each sample item (tuser 1) is checked against read,
// clock, live-fault, enable, latched-fault, OTG, VBUS, timeout and sample-limit
// conditions, and a verdict once reached is held until the next begin. Each item passes
// through an input register, then a result register; a new item is taken every cycle
// while the result side keeps up, and the whole check is one pass of compare logic
// between the two. Configuration writes are applied at once and must only happen while
// no item is in flight.
module boost_startup_supervisor
  import bss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // power_reg, status_reg, vbus_code, fault_latched, fault_live, elapsed_ms,
  // reads_ok, clock_ok, zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // func
  input  logic                  s_tuser,
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // verdict, fail_reason, transient_seen, zero pad
  output logic [OUT_DATA_W-1:0] m_tdata
);

  // configuration
  logic [8:0]  tol_window;
  logic [8:0]  settle_len;
  logic [15:0] timeout_lim;

  // attempt state
  logic        transient_flag, transient_flag_next;
  logic [15:0] clean_start_ms, clean_start_ms_next;
  logic [7:0]  sample_count, sample_count_next;
  verdict_t    held_verdict, held_verdict_next;
  reason_t     held_reason, held_reason_next;

  // input register
  logic        in_valid;
  func_t       in_func;
  logic [7:0]  in_power, in_status, in_vbus, in_latched, in_live;
  logic [15:0] in_elapsed;
  logic        in_reads_ok, in_clock_ok;

  // result register
  logic        out_valid;
  verdict_t    out_verdict;
  reason_t     out_reason;
  logic        out_seen;

  logic advance;
  logic otg, vbus_ok, fault_latched, fault_tolerable;
  logic [15:0] clean_ms;
  logic pass_ok;

  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_seen, out_reason, out_verdict};

  always_ff @(posedge clk) begin
    if (rst) begin
      tol_window  <= '0;
      settle_len  <= '0;
      timeout_lim <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WINDOW:  tol_window  <= cfg_data[8:0];
        CFG_STABLE:  settle_len  <= cfg_data[8:0];
        CFG_TIMEOUT: timeout_lim <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_func     <= func_t'(s_tuser);
      in_power    <= s_tdata[7:0];
      in_status   <= s_tdata[15:8];
      in_vbus     <= s_tdata[23:16];
      in_latched  <= s_tdata[31:24];
      in_live     <= s_tdata[39:32];
      in_elapsed  <= s_tdata[55:40];
      in_reads_ok <= s_tdata[56];
      in_clock_ok <= s_tdata[57];
    end
  end

  assign otg           = (in_status & OTG_MASK) == OTG_MASK;
  assign vbus_ok       = in_vbus[6:0] >= VCODE_MIN;
  assign fault_latched = (in_latched & FAULT_BIT) != '0;
  assign fault_tolerable = !transient_flag && (tol_window != '0) &&
                           (in_elapsed <= {7'd0, tol_window}) && otg;
  assign clean_ms = (in_elapsed >= clean_start_ms_next) ?
                    in_elapsed - clean_start_ms_next : '0;
  assign pass_ok  = otg && vbus_ok &&
                    (!transient_flag_next || clean_ms >= {7'd0, settle_len});

  always_comb begin
    transient_flag_next = transient_flag;
    clean_start_ms_next = clean_start_ms;
    sample_count_next   = sample_count;
    held_verdict_next   = held_verdict;
    held_reason_next    = held_reason;
    if (in_func == FUNC_BEGIN) begin
      transient_flag_next = 1'b0;
      clean_start_ms_next = '0;
      sample_count_next   = '0;
      held_verdict_next   = V_CHECK;
      held_reason_next    = R_NONE;
    end else if (held_verdict == V_CHECK) begin
      if (sample_count != COUNT_MAX) begin
        sample_count_next = sample_count + 8'd1;
      end
      // latched fault inside the window is tolerated once
      if (fault_latched && fault_tolerable) begin
        transient_flag_next = 1'b1;
        clean_start_ms_next = in_elapsed;
      end
      if (!in_reads_ok) begin
        held_verdict_next = V_FAIL;
        held_reason_next  = R_READ;
      end else if (!in_clock_ok) begin
        held_verdict_next = V_FAIL;
        held_reason_next  = R_CLOCK;
      end else if ((in_live & FAULT_BIT) != '0) begin
        held_verdict_next = V_FAIL;
        held_reason_next  = R_FAULT;
      end else if ((in_power & BOOST_EN_BIT) == '0) begin
        held_verdict_next = V_FAIL;
        held_reason_next  = R_DISABLED;
      end else if (fault_latched && !fault_tolerable) begin
        held_verdict_next = V_FAIL;
        held_reason_next  = R_REPEAT;
      end else if (transient_flag_next && !otg) begin
        held_verdict_next = V_FAIL;
        held_reason_next  = R_UNSTABLE;
      end else if (pass_ok) begin
        held_verdict_next = V_PASS;
        held_reason_next  = R_NONE;
      end else if (in_elapsed >= timeout_lim) begin
        held_verdict_next = V_FAIL;
        held_reason_next  = R_TIMEOUT;
      end else if (sample_count_next >= 8'(MAX_SAMPLES)) begin
        held_verdict_next = V_FAIL;
        held_reason_next  = R_LIMIT;
      end
      // drop the tolerated-fault capture when an earlier check already failed
      if (!in_reads_ok || !in_clock_ok || (in_live & FAULT_BIT) != '0 ||
          (in_power & BOOST_EN_BIT) == '0) begin
        transient_flag_next = transient_flag;
        clean_start_ms_next = clean_start_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      transient_flag <= 1'b0;
      clean_start_ms <= '0;
      sample_count   <= '0;
      held_verdict   <= V_CHECK;
      held_reason    <= R_NONE;
      out_valid      <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
      if (in_valid) begin
        transient_flag <= transient_flag_next;
        clean_start_ms <= clean_start_ms_next;
        sample_count   <= sample_count_next;
        held_verdict   <= held_verdict_next;
        held_reason    <= held_reason_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_verdict <= held_verdict_next;
      out_reason  <= held_reason_next;
      out_seen    <= transient_flag_next;
    end
  end

`ifndef SYNTH
  a_reason_none_unless_fail: assert property (@(posedge clk) disable iff (rst)
    (held_verdict != V_FAIL) |-> (held_reason == R_NONE))
    else $error("held reason set without a failed verdict");

  a_fail_has_reason: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_verdict == V_FAIL) |-> (out_reason != R_NONE))
    else $error("failed result without a reason");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    sample_count <= 8'(MAX_SAMPLES))
    else $error("sample count ran past the limit");

  a_clean_start_clear: assert property (@(posedge clk) disable iff (rst)
    !transient_flag |-> (clean_start_ms == '0))
    else $error("clean start set without a tolerated fault");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready) |=> $stable(held_verdict) && $stable(sample_count))
    else $error("attempt state moved while result stalled");
`endif

endmodule
